// File: rtl/core/wgft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgft_pkg
// Shared types, constants and the sequencer program of the Winograd
// F(4x4,3x3) filter transform.
// ----------------------------------------------------------------------------
package wgft_pkg;

    localparam int TAP_WIDTH_DEF = 16;
    localparam int VALUE_WIDTH   = 26;
    localparam int POS_WIDTH     = 6;
    localparam int TILE          = 6;
    localparam int KSIZE         = 3;
    localparam int NUM_TAPS      = KSIZE * KSIZE;
    localparam int NUM_ENTRIES   = TILE * TILE;
    localparam int ROW_WIDTH     = 3;
    localparam int STEP_WIDTH    = 6;
    localparam int FIRST_COLUMN  = 1;
    localparam int FIRST_EMIT    = FIRST_COLUMN + TILE;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_COLUMN,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT,
        JMP_ALWAYS
    } jump_t;

    // Entries of the integer transform matrix 24*G.
    typedef enum logic [2:0] {
        C_ZERO,
        C_P1,
        C_P2,
        C_M2,
        C_P4,
        C_M4,
        C_P6,
        C_P24
    } coef_t;

    typedef struct packed {
        op_t                  op;
        logic [ROW_WIDTH-1:0] row;
        logic [ROW_WIDTH-1:0] col;
        logic [POS_WIDTH-1:0] pos;
        logic                 last;
        jump_t                jump;
        logic [STEP_WIDTH-1:0] target;
    } uword_t;

    typedef struct packed {
        logic   load;
        uword_t uw;
    } ctrl_t;

    function automatic coef_t hcoef(input logic [ROW_WIDTH-1:0] row, input logic [1:0] k);
        coef_t c;
        c = C_ZERO;
        unique case (row)
            3'd0:    c = (k == 2'd0) ? C_P6 : C_ZERO;
            3'd1:    c = C_M4;
            3'd2:    c = (k == 2'd1) ? C_P4 : C_M4;
            3'd3:    c = (k == 2'd0) ? C_P1 : ((k == 2'd1) ? C_P2 : C_P4);
            3'd4:    c = (k == 2'd0) ? C_P1 : ((k == 2'd1) ? C_M2 : C_P4);
            3'd5:    c = (k == 2'd2) ? C_P24 : C_ZERO;
            default: c = C_ZERO;
        endcase
        return c;
    endfunction

    // Program ROM: one idle step that waits for start, six steps that form
    // the rows of H*g, then 36 emit steps; the last one jumps home.
    function automatic uword_t ucode(input logic [STEP_WIDTH-1:0] step);
        uword_t w;
        w        = '0;
        w.op     = OP_IDLE;
        w.jump   = (step == '0) ? JMP_WAIT : JMP_ALWAYS;
        w.target = '0;
        for (int i = 0; i < TILE; i++) begin
            if (step == STEP_WIDTH'(FIRST_COLUMN + i)) begin
                w.op   = OP_COLUMN;
                w.row  = ROW_WIDTH'(i);
                w.jump = JMP_NEXT;
            end
            for (int j = 0; j < TILE; j++) begin
                if (step == STEP_WIDTH'(FIRST_EMIT + i * TILE + j)) begin
                    w.op   = OP_EMIT;
                    w.row  = ROW_WIDTH'(i);
                    w.col  = ROW_WIDTH'(j);
                    w.pos  = POS_WIDTH'(i * TILE + j);
                    w.last = (i * TILE + j == NUM_ENTRIES - 1);
                    w.jump = w.last ? JMP_ALWAYS : JMP_NEXT;
                end
            end
        end
        return w;
    endfunction

endpackage

// File: rtl/core/winograd_f4x3_filter_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winograd_f4x3_filter_transform
// Winograd F(4x4,3x3) filter transform of one 3x3 kernel, scaled by 576.
// ----------------------------------------------------------------------------
// A kernel of nine signed taps is transferred at a rising edge with start
// high and busy low. The block then emits the 36 entries of (24G)g(24G)^T
// in row-major order, one per cycle: valid is high for exactly one cycle
// per entry, with position (row*6+column), value (exact, 576 times the true
// entry in the taps' format) and last on the 36th entry.
// The receiver cannot stall; every entry must be taken when valid is high.
// After its emit step, each entry passes the stored-row register and then
// the output register.
// The microprogram has one idle step, six steps that form the rows of H*g
// in a three-lane shift-add unit, and 36 emit steps that each read one
// stored row.
// Busy drops after the last emit step; a new kernel may be transferred
// while the final two entries are still in the output pipeline.
// Reset clears the step counter and the output strobe; no entry is pending.
// ----------------------------------------------------------------------------
module winograd_f4x3_filter_transform #(
    parameter int TAP_WIDTH = wgft_pkg::TAP_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [TAP_WIDTH-1:0]             tap_00,
    input  logic signed [TAP_WIDTH-1:0]             tap_01,
    input  logic signed [TAP_WIDTH-1:0]             tap_02,
    input  logic signed [TAP_WIDTH-1:0]             tap_10,
    input  logic signed [TAP_WIDTH-1:0]             tap_11,
    input  logic signed [TAP_WIDTH-1:0]             tap_12,
    input  logic signed [TAP_WIDTH-1:0]             tap_20,
    input  logic signed [TAP_WIDTH-1:0]             tap_21,
    input  logic signed [TAP_WIDTH-1:0]             tap_22,
    output logic                                    valid,
    output logic [wgft_pkg::POS_WIDTH-1:0]          position,
    output logic signed [wgft_pkg::VALUE_WIDTH-1:0] value,
    output logic                                    last
);
    import wgft_pkg::*;

    ctrl_t                       ctrl;
    logic signed [TAP_WIDTH-1:0] taps [NUM_TAPS];

    assign taps[0] = tap_00;
    assign taps[1] = tap_01;
    assign taps[2] = tap_02;
    assign taps[3] = tap_10;
    assign taps[4] = tap_11;
    assign taps[5] = tap_12;
    assign taps[6] = tap_20;
    assign taps[7] = tap_21;
    assign taps[8] = tap_22;

    wgft_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    wgft_datapath #(
        .TAP_WIDTH (TAP_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .taps     (taps),
        .valid    (valid),
        .position (position),
        .value    (value),
        .last     (last)
    );

endmodule

// File: rtl/core/wgft_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgft_sequencer
// Step counter and program ROM that drive the transform datapath.
// ----------------------------------------------------------------------------
module wgft_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output wgft_pkg::ctrl_t ctrl
);
    import wgft_pkg::*;

    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    uword_t                uw;

    assign uw        = ucode(step_reg);
    assign busy      = (uw.op != OP_IDLE);
    assign ctrl.load = start && !busy;
    assign ctrl.uw   = uw;

    always_comb
    begin
        unique case (uw.jump)
            JMP_NEXT:   step_next = step_reg + STEP_WIDTH'(1);
            JMP_WAIT:   step_next = start ? step_reg + STEP_WIDTH'(1) : step_reg;
            JMP_ALWAYS: step_next = uw.target;
            default:    step_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_accept_starts_column: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (uw.op == OP_COLUMN) && (uw.row == '0))
        else $error("accepted kernel did not enter the first column step");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_EMIT) && uw.last |=> !busy)
        else $error("sequencer did not return to idle after the last entry");

    a_emit_follows_column: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_EMIT) && (uw.pos == '0) |-> $past(uw.op) == OP_COLUMN)
        else $error("emit started without the column pass");

endmodule

// File: rtl/core/wgft_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgft_datapath
// Tap registers, the H*g row store and the shift-add logic that forms the
// two passes of the transform.
// ----------------------------------------------------------------------------
module wgft_datapath #(
    parameter int TAP_WIDTH = wgft_pkg::TAP_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wgft_pkg::ctrl_t                     ctrl,
    input  logic signed [TAP_WIDTH-1:0]         taps [wgft_pkg::NUM_TAPS],
    output logic                                valid,
    output logic [wgft_pkg::POS_WIDTH-1:0]      position,
    output logic signed [wgft_pkg::VALUE_WIDTH-1:0] value,
    output logic                                last
);
    import wgft_pkg::*;

    localparam int CP_WIDTH  = TAP_WIDTH + 5;
    localparam int ACC_WIDTH = TAP_WIDTH + 10;
    localparam int EXT_WIDTH = (ACC_WIDTH > VALUE_WIDTH) ? ACC_WIDTH : VALUE_WIDTH;

    logic signed [TAP_WIDTH-1:0]     tap_reg [NUM_TAPS];
    logic [KSIZE*CP_WIDTH-1:0]       cp_mem [TILE];
    logic [KSIZE*CP_WIDTH-1:0]       rd_reg;
    logic [KSIZE*CP_WIDTH-1:0]       row_data;
    logic                            emit_reg;
    logic [ROW_WIDTH-1:0]            col_reg;
    logic [POS_WIDTH-1:0]            pos_reg;
    logic                            last_pipe_reg;
    logic                            valid_reg;
    logic [POS_WIDTH-1:0]            position_reg;
    logic signed [VALUE_WIDTH-1:0]   value_reg;
    logic                            last_reg;
    logic signed [EXT_WIDTH-1:0]     acc;

    function automatic logic signed [EXT_WIDTH-1:0] scale(
        input logic signed [EXT_WIDTH-1:0] x,
        input coef_t                       c
    );
        logic signed [EXT_WIDTH-1:0] r;
        unique case (c)
            C_ZERO:  r = '0;
            C_P1:    r = x;
            C_P2:    r = x <<< 1;
            C_M2:    r = -(x <<< 1);
            C_P4:    r = x <<< 2;
            C_M4:    r = -(x <<< 2);
            C_P6:    r = (x <<< 2) + (x <<< 1);
            C_P24:   r = (x <<< 4) + (x <<< 3);
            default: r = '0;
        endcase
        return r;
    endfunction

    // First pass: one row of H*g, all three columns side by side.
    always_comb
    begin
        logic signed [EXT_WIDTH-1:0] sum;
        logic signed [EXT_WIDTH-1:0] g_ext;
        row_data = '0;
        for (int c = 0; c < KSIZE; c++) begin
            sum = '0;
            for (int k = 0; k < KSIZE; k++) begin
                g_ext = {{(EXT_WIDTH-TAP_WIDTH){tap_reg[k*KSIZE+c][TAP_WIDTH-1]}},
                         tap_reg[k*KSIZE+c]};
                sum = sum + scale(g_ext, hcoef(ctrl.uw.row, 2'(k)));
            end
            row_data[c*CP_WIDTH +: CP_WIDTH] = sum[CP_WIDTH-1:0];
        end
    end

    // Second pass: one entry of (H*g)*H^T from the stored row.
    always_comb
    begin
        logic signed [EXT_WIDTH-1:0] p_ext;
        logic [CP_WIDTH-1:0]         p;
        acc = '0;
        for (int k = 0; k < KSIZE; k++) begin
            p     = rd_reg[k*CP_WIDTH +: CP_WIDTH];
            p_ext = {{(EXT_WIDTH-CP_WIDTH){p[CP_WIDTH-1]}}, p};
            acc   = acc + scale(p_ext, hcoef(col_reg, 2'(k)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int t = 0; t < NUM_TAPS; t++) begin
                tap_reg[t] <= taps[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.uw.op == OP_COLUMN)
        begin
            cp_mem[ctrl.uw.row] <= row_data;
        end
        if (ctrl.uw.op == OP_EMIT)
        begin
            rd_reg <= cp_mem[ctrl.uw.row];
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= ctrl.uw.col;
        pos_reg       <= ctrl.uw.pos;
        last_pipe_reg <= ctrl.uw.last;
        position_reg  <= pos_reg;
        value_reg     <= acc[VALUE_WIDTH-1:0];
        last_reg      <= last_pipe_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            emit_reg  <= (ctrl.uw.op == OP_EMIT);
            valid_reg <= emit_reg;
        end
    end

    assign valid    = valid_reg;
    assign position = position_reg;
    assign value    = value_reg;
    assign last     = valid_reg && last_reg;

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> position == POS_WIDTH'(NUM_ENTRIES - 1))
        else $error("last flag on an entry other than the final one");

    a_positions_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (position != '0) |-> $past(valid) &&
            (position == $past(position) + POS_WIDTH'(1)))
        else $error("entries out of order or with a gap");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> position < POS_WIDTH'(NUM_ENTRIES))
        else $error("entry position beyond the tile");

endmodule
